// ----- src/stra_pkg.sv -----
package stra_pkg;

    localparam int LEAVES = 1024;
    localparam int PAD    = 1 << $clog2(LEAVES);
    localparam int NODES  = 2 * PAD;
    localparam int ADDR_W = $clog2(NODES);
    localparam int POS_W  = ADDR_W + 1;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int END_W  = 11;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_SUM = 2'd2;

    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_WRITE,
        S_UPD_READ,
        S_UPD_COMB,
        S_QRY_LEFT,
        S_QRY_LACC,
        S_QRY_RIGHT,
        S_QRY_RACC,
        S_QRY_DONE
    } t_state;

    function automatic logic signed [DATA_W-1:0] identity_of(input logic [1:0] mode);
        logic signed [DATA_W-1:0] id;
        unique case (mode)
            MODE_MIN: id = {1'b0, {(DATA_W-1){1'b1}}};
            MODE_MAX: id = {1'b1, {(DATA_W-1){1'b0}}};
            default:  id = '0;
        endcase
        return id;
    endfunction

endpackage

// ----- src/segment_tree_range_aggregate.sv -----
// Segment tree over 1024 signed 32-bit leaves, aggregated by min, max or
// wrapping sum as i_cfg_wdata selects (0 min, 1 max, 2 or 3 sum).
// Input channel i_in_valid/o_in_stall carries one item: action 0 writes
// i_leaf_value at i_leaf_index and refreshes its ancestors, action 1 queries
// leaves [i_range_start, i_range_end), action 2 clears the tree, action 3
// does nothing. Only a query produces an item on o_out_valid/i_out_stall.
// Node storage is one single-port-write RAM with a registered read, and one
// min/max/add unit is shared by every step, so items are taken one at a time.
// Update: one leaf write, then one read and one combine per level up to
// the root. Query: a left and a right step per tree level, each with an
// optional read and combine; an empty range goes straight to the result.
// Clear writes the identity to all 2048 nodes, one node per cycle, and also
// runs after reset and after each mode write, o_in_stall high. The result
// sits in an output register; the block returns to idle while it waits, and
// only the next query's result waits for the receiver to release i_out_stall.
module segment_tree_range_aggregate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic [stra_pkg::IDX_W-1:0]          i_leaf_index,
    input  logic signed [stra_pkg::DATA_W-1:0]  i_leaf_value,
    input  logic [stra_pkg::IDX_W-1:0]          i_range_start,
    input  logic [stra_pkg::END_W-1:0]          i_range_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [stra_pkg::DATA_W-1:0]  o_aggregate
);
    import stra_pkg::*;

    t_state                    r_state, n_state;
    logic [1:0]                r_mode, n_mode;
    logic [ADDR_W-1:0]         r_cnt, n_cnt;
    logic [POS_W-1:0]          r_l, n_l;
    logic [POS_W-1:0]          r_r, n_r;
    logic signed [DATA_W-1:0]  r_acc, n_acc;
    logic signed [DATA_W-1:0]  r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  alu_y;
    logic signed [DATA_W-1:0]  ident;
    logic [POS_W-1:0]          right_dec;
    logic [POS_W-1:0]          start_sat;
    logic [POS_W-1:0]          end_sat;
    logic                      in_accept;

    stra_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stra_alu u_alu (
        .i_mode (r_mode),
        .i_a    (r_acc),
        .i_b    (ram_rdata),
        .o_y    (alu_y)
    );

    assign ident      = identity_of(r_mode);
    assign right_dec  = r_r - POS_W'(1);
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Saturate query bounds to the leaf count.
    assign start_sat = (POS_W'(i_range_start) > POS_W'(LEAVES)) ? POS_W'(LEAVES)
                                                                 : POS_W'(i_range_start);
    assign end_sat   = (POS_W'(i_range_end) > POS_W'(LEAVES)) ? POS_W'(LEAVES)
                                                               : POS_W'(i_range_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mode      <= MODE_SUM;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l   <= n_l;
        r_r   <= n_r;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_l         = r_l;
        n_r         = r_r;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt;
        ram_wdata   = ident;
        ram_raddr   = r_l[ADDR_W-1:0];

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = ident;
                n_cnt     = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_action)
                        ACT_UPDATE: begin
                            if (POS_W'(i_leaf_index) < POS_W'(LEAVES)) begin
                                n_acc   = i_leaf_value;
                                n_l     = POS_W'(PAD) + POS_W'(i_leaf_index);
                                n_state = S_UPD_WRITE;
                            end
                        end
                        ACT_QUERY: begin
                            n_acc   = ident;
                            n_l     = POS_W'(PAD) + start_sat;
                            n_r     = POS_W'(PAD) + end_sat;
                            n_state = S_QRY_LEFT;
                        end
                        ACT_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_UPD_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_l[ADDR_W-1:0];
                ram_wdata = r_acc;
                n_state   = (r_l == POS_W'(1)) ? S_IDLE : S_UPD_READ;
            end
            S_UPD_READ: begin
                // Fetch the sibling; the other child is held in r_acc.
                ram_raddr = r_l[ADDR_W-1:0] ^ ADDR_W'(1);
                n_state   = S_UPD_COMB;
            end
            S_UPD_COMB: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_l[POS_W-1:1]);
                ram_wdata = alu_y;
                n_acc     = alu_y;
                n_l       = r_l >> 1;
                n_state   = (r_l[POS_W-1:1] == (POS_W-1)'(1)) ? S_IDLE : S_UPD_READ;
            end
            S_QRY_LEFT: begin
                if (r_l >= r_r) begin
                    n_state = S_QRY_DONE;
                end else if (r_l[0]) begin
                    ram_raddr = r_l[ADDR_W-1:0];
                    n_l       = r_l + POS_W'(1);
                    n_state   = S_QRY_LACC;
                end else begin
                    n_state = S_QRY_RIGHT;
                end
            end
            S_QRY_LACC: begin
                n_acc   = alu_y;
                n_state = S_QRY_RIGHT;
            end
            S_QRY_RIGHT: begin
                if (r_r[0]) begin
                    ram_raddr = right_dec[ADDR_W-1:0];
                    n_r       = right_dec;
                    n_state   = S_QRY_RACC;
                end else begin
                    n_l     = r_l >> 1;
                    n_r     = r_r >> 1;
                    n_state = S_QRY_LEFT;
                end
            end
            S_QRY_RACC: begin
                n_acc   = alu_y;
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = S_QRY_LEFT;
            end
            S_QRY_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A mode write restarts the clearing pass with the new identity.
        if (i_cfg_we) begin
            n_mode  = i_cfg_wdata;
            n_cnt   = '0;
            n_state = S_CLEAR;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_aggregate = r_out;

endmodule

// ----- src/stra_ram.sv -----
module stra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/stra_alu.sv -----
module stra_alu (
    input  logic [1:0]                         i_mode,
    input  logic signed [stra_pkg::DATA_W-1:0] i_a,
    input  logic signed [stra_pkg::DATA_W-1:0] i_b,
    output logic signed [stra_pkg::DATA_W-1:0] o_y
);
    import stra_pkg::*;

    always_comb begin
        unique case (i_mode)
            MODE_MIN: o_y = (i_a <= i_b) ? i_a : i_b;
            MODE_MAX: o_y = (i_a >= i_b) ? i_a : i_b;
            default:  o_y = i_a + i_b;
        endcase
    end

endmodule
